>>> sv/pwlcr_pkg.sv
// Shared types, codes and constants of the pulse-width LED command receiver.
package pwlcr_pkg;

	// Field widths
	localparam int PULSE_W     = 8;
	localparam int THRESH_W    = 8;
	localparam int FRAME_W     = 16;
	localparam int POS_W       = 5;
	localparam int NIBBLE_W    = 4;
	localparam int DUTY_W      = 8;
	localparam int SETUP_W     = 8;
	localparam int MODE_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int REG_INDEX_W = 1;

	// Channel slots on the result, and the default number actually fitted
	localparam int MAX_CHANNELS          = 3;
	localparam int DEFAULT_CHANNEL_COUNT = 3;

	// Bit position codes: a complete frame, waiting for a break, and the last bit
	localparam logic [POS_W-1:0] POS_FULL       = 5'd16;
	localparam logic [POS_W-1:0] POS_NOT_SYNCED = 5'd17;
	localparam logic [POS_W-1:0] POS_LAST_BIT   = 5'd15;

	// Reset values
	localparam logic [THRESH_W-1:0] BREAK_THRESHOLD_RESET = 8'd8;
	localparam logic [THRESH_W-1:0] ONE_THRESHOLD_RESET   = 8'd4;
	localparam logic [NIBBLE_W-1:0] ADDRESS_RESET         = 4'hf;

	// Low nibble that marks a configuration frame; also the unusable address
	localparam logic [NIBBLE_W-1:0] CONFIG_NIBBLE = 4'hf;

	// Highest mode value plus one
	localparam logic [NIBBLE_W-1:0] MODE_LIMIT = 4'd3;

	// Configuration register indexes
	localparam logic [REG_INDEX_W-1:0] REG_BREAK_THRESHOLD = 1'd0;
	localparam logic [REG_INDEX_W-1:0] REG_ONE_THRESHOLD   = 1'd1;

	// Configuration frame opcodes
	localparam logic [NIBBLE_W-1:0] OP_ADDRESS    = 4'd0;
	localparam logic [NIBBLE_W-1:0] OP_MODE       = 4'd1;
	localparam logic [NIBBLE_W-1:0] OP_LOW_FIRST  = 4'd2;
	localparam logic [NIBBLE_W-1:0] OP_LOW_LAST   = 4'd4;
	localparam logic [NIBBLE_W-1:0] OP_GAIN_FIRST = 4'd5;
	localparam logic [NIBBLE_W-1:0] OP_GAIN_LAST  = 4'd7;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		STATUS_UNADDRESSED = 2'd0,
		STATUS_DRIVE       = 2'd1,
		STATUS_APPLIED     = 2'd2,
		STATUS_REJECTED    = 2'd3
	} status_t;

	// A completed frame handed from the deframer to the command stage
	typedef struct packed {
		logic               valid;
		logic [FRAME_W-1:0] bits;
	} frame_t;

	// One result transaction
	typedef struct packed {
		logic [NIBBLE_W-1:0]                  node_address;
		logic [MODE_W-1:0]                    common_mode;
		logic [MAX_CHANNELS-1:0]              output_enables;
		logic [MAX_CHANNELS-1:0][DUTY_W-1:0]  duty;
		status_t                              status;
	} result_t;

endpackage

>>> sv/pulse_width_led_command_receiver_unit.sv
// Top level of the pulse-width LED command receiver.
// Each input transaction carries one measured low-pulse length. The block takes a new pulse in
// every clock cycle unless stalled; a pulse is classified and shifted into the frame in the
// cycle it is accepted. A pulse completing a sixteen-bit frame loads the frame register, and
// the command is decoded into the output register once that is free. Only the pulse that
// completes a frame yields a result; breaks, data bits and stray pulses yield none. The input
// stalls only while a completed frame waits behind a result not yet taken. Thresholds are to
// be written through the configuration port only while no pulse is in flight; not enforced.
module pulse_width_led_command_receiver_unit #(
	parameter int CHANNEL_COUNT = pwlcr_pkg::DEFAULT_CHANNEL_COUNT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port
	input  logic                              cfg_we,
	input  logic [pwlcr_pkg::REG_INDEX_W-1:0] cfg_index,
	input  logic [pwlcr_pkg::THRESH_W-1:0]    cfg_wdata,
	// Pulse stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,  // [7:0] pulse_length
	// Result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [1:0] status, [9:2] duty_first, [17:10] duty_second, [25:18] duty_third,
	// [28:26] output_enables, [30:29] common_mode, [34:31] node_address, [39:35] zero
	output logic [39:0]                       m_tdata
);

	pwlcr_pkg::frame_t  frame_s1;
	pwlcr_pkg::result_t result_q;
	logic               stage_free;
	logic               s_accept;

	// A new pulse is refused only while a finished frame cannot move on.
	assign s_tready = !frame_s1.valid || stage_free;
	assign s_accept = s_tvalid && s_tready;

	pwlcr_deframer u_deframer (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.accept       (s_accept),
		.pulse_length (s_tdata[pwlcr_pkg::PULSE_W-1:0]),
		.consume      (stage_free),
		.frame_s1     (frame_s1)
	);

	pwlcr_exec #(
		.CHANNEL_COUNT (CHANNEL_COUNT)
	) u_exec (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_s1    (frame_s1),
		.out_ready   (m_tready),
		.stage_free  (stage_free),
		.out_valid_q (m_tvalid),
		.result_q    (result_q)
	);

	// Pack the result fields, first field lowest.
	assign m_tdata = {5'd0, result_q.node_address, result_q.common_mode,
		result_q.output_enables, result_q.duty[2], result_q.duty[1], result_q.duty[0],
		result_q.status};

	// A result only ever appears the cycle after a completed frame was waiting.
	a_result_from_frame: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(frame_s1.valid))
		else $error("result appeared without a completed frame");

	// A drive frame can never have matched the reserved address.
	a_drive_address: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (result_q.status == pwlcr_pkg::STATUS_DRIVE)
		|-> (result_q.node_address != pwlcr_pkg::CONFIG_NIBBLE))
		else $error("drive result with reserved node address");

	// The mode register never holds the unused code.
	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (result_q.common_mode != 2'd3))
		else $error("common mode out of range");

	// A pending frame never coexists with an accepted pulse that could overwrite it.
	a_no_frame_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		frame_s1.valid && !stage_free |=> frame_s1.valid && $stable(frame_s1.bits))
		else $error("pending frame lost while the result stage was busy");

endmodule

>>> sv/pwlcr_deframer.sv
// Pulse classification, frame assembly and the threshold registers.
module pwlcr_deframer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pwlcr_pkg::REG_INDEX_W-1:0] cfg_index,
	input  logic [pwlcr_pkg::THRESH_W-1:0]    cfg_wdata,
	input  logic                              accept,
	input  logic [pwlcr_pkg::PULSE_W-1:0]     pulse_length,
	input  logic                              consume,
	output pwlcr_pkg::frame_t                 frame_s1
);

	logic [pwlcr_pkg::THRESH_W-1:0] break_threshold_q;
	logic [pwlcr_pkg::THRESH_W-1:0] one_threshold_q;
	logic [pwlcr_pkg::POS_W-1:0]    bit_position_q;
	logic [pwlcr_pkg::FRAME_W-1:0]  frame_bits_q;
	logic [pwlcr_pkg::FRAME_W-1:0]  bits_next;
	logic                           is_break;
	logic                           in_frame;
	logic                           completes;

	// Threshold registers, written through the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			break_threshold_q <= pwlcr_pkg::BREAK_THRESHOLD_RESET;
			one_threshold_q   <= pwlcr_pkg::ONE_THRESHOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pwlcr_pkg::REG_BREAK_THRESHOLD: break_threshold_q <= cfg_wdata;
				pwlcr_pkg::REG_ONE_THRESHOLD:   one_threshold_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Classify the pulse and work out the frame word with this bit set.
	always_comb begin
		is_break  = pulse_length >= break_threshold_q;
		in_frame  = !bit_position_q[pwlcr_pkg::POS_W-1];
		bits_next = frame_bits_q;
		if (pulse_length >= one_threshold_q) begin
			bits_next[bit_position_q[pwlcr_pkg::POS_W-2:0]] = 1'b1;
		end
		completes = !is_break && (bit_position_q == pwlcr_pkg::POS_LAST_BIT);
	end

	// Bit counter and shift word. A break restarts the frame at any time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_position_q <= pwlcr_pkg::POS_NOT_SYNCED;
			frame_bits_q   <= '0;
		end else if (accept) begin
			if (is_break) begin
				bit_position_q <= '0;
				frame_bits_q   <= '0;
			end else if (in_frame) begin
				bit_position_q <= bit_position_q + 1'b1;
				frame_bits_q   <= bits_next;
			end
		end
	end

	// Completed frame register, held until the command stage takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_s1 <= '0;
		end else if (accept && completes) begin
			frame_s1.valid <= 1'b1;
			frame_s1.bits  <= bits_next;
		end else if (consume) begin
			frame_s1.valid <= 1'b0;
		end
	end

endmodule

>>> sv/pwlcr_exec.sv
// Command decode, node settings, channel duty arithmetic and the result register.
module pwlcr_exec #(
	parameter int CHANNEL_COUNT = pwlcr_pkg::DEFAULT_CHANNEL_COUNT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pwlcr_pkg::frame_t  frame_s1,
	input  logic               out_ready,
	output logic               stage_free,
	output logic               out_valid_q,
	output pwlcr_pkg::result_t result_q
);

	localparam int NCH = pwlcr_pkg::MAX_CHANNELS;
	localparam logic [NCH-1:0] CH_MASK = NCH'((1 << CHANNEL_COUNT) - 1);

	logic [pwlcr_pkg::NIBBLE_W-1:0] address_q;
	logic [pwlcr_pkg::MODE_W-1:0]   mode_q;
	logic [pwlcr_pkg::SETUP_W-1:0]  setup_q [NCH];
	logic [pwlcr_pkg::DUTY_W-1:0]   duty_q  [NCH];
	logic [NCH-1:0]                 enable_q;

	logic [pwlcr_pkg::NIBBLE_W-1:0] address_d;
	logic [pwlcr_pkg::MODE_W-1:0]   mode_d;
	logic [pwlcr_pkg::SETUP_W-1:0]  setup_d [NCH];
	logic [pwlcr_pkg::DUTY_W-1:0]   duty_d  [NCH];
	logic [NCH-1:0]                 enable_d;
	pwlcr_pkg::status_t             status_d;
	pwlcr_pkg::result_t             result_d;

	logic [pwlcr_pkg::NIBBLE_W-1:0] nibs [4];
	logic [pwlcr_pkg::NIBBLE_W-1:0] op;
	logic [pwlcr_pkg::NIBBLE_W-1:0] arg;
	logic [pwlcr_pkg::NIBBLE_W-1:0] check;
	logic [pwlcr_pkg::NIBBLE_W-1:0] ch;
	logic [pwlcr_pkg::NIBBLE_W-1:0] value;
	logic [1:0]                     sel;
	logic [8:0]                     product;
	logic                           go;

	assign stage_free = !out_valid_q || out_ready;
	assign go         = frame_s1.valid && stage_free;

	// Next settings and status for the frame in the input register.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			nibs[k] = frame_s1.bits[k*4 +: 4];
		end
		op    = nibs[1];
		arg   = nibs[2];
		check = ~nibs[3];
		ch    = '0;
		value = '0;
		sel   = '0;
		product = '0;

		address_d = address_q;
		mode_d    = mode_q;
		enable_d  = enable_q;
		for (int i = 0; i < NCH; i++) begin
			setup_d[i] = setup_q[i];
			duty_d[i]  = duty_q[i];
		end

		if (nibs[0] == pwlcr_pkg::CONFIG_NIBBLE) begin
			status_d = pwlcr_pkg::STATUS_REJECTED;
			if ((op ^ arg) == check) begin
				case (op) inside
					pwlcr_pkg::OP_ADDRESS: begin
						if (arg != pwlcr_pkg::CONFIG_NIBBLE) begin
							address_d = arg;
							status_d  = pwlcr_pkg::STATUS_APPLIED;
						end
					end
					pwlcr_pkg::OP_MODE: begin
						if (arg < pwlcr_pkg::MODE_LIMIT) begin
							mode_d   = arg[pwlcr_pkg::MODE_W-1:0];
							enable_d = '0;
							status_d = pwlcr_pkg::STATUS_APPLIED;
						end
					end
					[pwlcr_pkg::OP_LOW_FIRST:pwlcr_pkg::OP_LOW_LAST]: begin
						ch = op - pwlcr_pkg::OP_LOW_FIRST;
						if (ch < 4'(CHANNEL_COUNT)) begin
							enable_d = '0;
							status_d = pwlcr_pkg::STATUS_APPLIED;
							for (int i = 0; i < NCH; i++) begin
								if (ch == 4'(i)) begin
									setup_d[i][3:0] = arg;
								end
							end
						end
					end
					[pwlcr_pkg::OP_GAIN_FIRST:pwlcr_pkg::OP_GAIN_LAST]: begin
						ch = op - pwlcr_pkg::OP_GAIN_FIRST;
						if (ch < 4'(CHANNEL_COUNT)) begin
							enable_d = '0;
							status_d = pwlcr_pkg::STATUS_APPLIED;
							for (int i = 0; i < NCH; i++) begin
								if (ch == 4'(i)) begin
									setup_d[i][7:4] = arg;
								end
							end
						end
					end
					default: status_d = pwlcr_pkg::STATUS_REJECTED;
				endcase
			end
		end else if (nibs[0] != address_q) begin
			status_d = pwlcr_pkg::STATUS_UNADDRESSED;
		end else begin
			// Drive frame: each fitted channel with a nibble selected is updated.
			status_d = pwlcr_pkg::STATUS_DRIVE;
			for (int i = 0; i < NCH; i++) begin
				if (i < CHANNEL_COUNT) begin
					sel     = setup_q[i][3:2];
					value   = nibs[sel];
					product = value * ({1'b0, setup_q[i][7:4]} + 5'd1);
					if (sel != 2'd0) begin
						if (value == '0) begin
							enable_d[i] = 1'b0;
						end else begin
							duty_d[i]   = 8'(product >> setup_q[i][1:0]);
							enable_d[i] = 1'b1;
						end
					end
				end
			end
		end

		// Result fields reflect the settings after this frame.
		result_d.status         = status_d;
		result_d.node_address   = address_d;
		result_d.common_mode    = mode_d;
		result_d.output_enables = enable_d & CH_MASK;
		for (int i = 0; i < NCH; i++) begin
			result_d.duty[i] = (i < CHANNEL_COUNT) ? duty_d[i] : '0;
		end
	end

	// Node settings, updated once per completed frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_q <= pwlcr_pkg::ADDRESS_RESET;
			mode_q    <= '0;
			enable_q  <= '0;
			for (int i = 0; i < NCH; i++) begin
				setup_q[i] <= '0;
				duty_q[i]  <= '0;
			end
		end else if (go) begin
			address_q <= address_d;
			mode_q    <= mode_d;
			enable_q  <= enable_d;
			for (int i = 0; i < NCH; i++) begin
				setup_q[i] <= setup_d[i];
				duty_q[i]  <= duty_d[i];
			end
		end
	end

	// Result register and its valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			result_q <= result_d;
		end
	end

endmodule

>>> sim/tb_pulse_width_led_command_receiver_unit.sv
// Self-checking testbench for the pulse-width LED command receiver unit.
module tb_pulse_width_led_command_receiver_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LED_CHANNELS      = pwlcr_pkg::DEFAULT_CHANNEL_COUNT;
	localparam int ITEMS_PER_SEGMENT = 120;
	localparam int SEGMENTS          = 6;
	localparam int DRAIN_CYCLES      = 4;
	localparam int DRAIN_LIMIT       = 5000;
	localparam int PLAN_LEN          = 23;
	localparam int RESULT_W          = $bits(pwlcr_pkg::result_t);
	localparam logic [pwlcr_pkg::PULSE_W-1:0] PULSE_MAX = 8'hff;

	// One row of the directed plan: thresholds, the pulses sent ahead of the frame, the frame, and its expected status.
	typedef struct {
		logic [pwlcr_pkg::THRESH_W-1:0] brk;
		logic [pwlcr_pkg::THRESH_W-1:0] one;
		int                             strays;
		int                             partial;
		logic [pwlcr_pkg::FRAME_W-1:0]  bits;
		bit                             tight;
		bit                             known;
		pwlcr_pkg::status_t             status;
	} plan_row_t;

	logic                              clk       = 1'b0;
	logic                              arst_n    = 1'b0;
	logic                              cfg_we    = 1'b0;
	logic [pwlcr_pkg::REG_INDEX_W-1:0] cfg_index = '0;
	logic [pwlcr_pkg::THRESH_W-1:0]    cfg_wdata = '0;
	logic                              s_tvalid  = 1'b0;
	logic                              s_tready;
	logic [7:0]                        s_tdata   = '0;  // [7:0] pulse_length
	logic                              m_tvalid;
	logic                              m_tready  = 1'b0;
	// [1:0] status, [9:2] duty_first, [17:10] duty_second, [25:18] duty_third,
	// [28:26] output_enables, [30:29] common_mode, [34:31] node_address, [39:35] zero
	logic [39:0]                       m_tdata;

	// Receiver state as the testbench expects it, starting from its reset values.
	logic [pwlcr_pkg::THRESH_W-1:0]     thr_break = pwlcr_pkg::BREAK_THRESHOLD_RESET;
	logic [pwlcr_pkg::THRESH_W-1:0]     thr_one   = pwlcr_pkg::ONE_THRESHOLD_RESET;
	logic [pwlcr_pkg::POS_W-1:0]        rx_pos    = pwlcr_pkg::POS_NOT_SYNCED;
	logic [pwlcr_pkg::FRAME_W-1:0]      rx_bits   = '0;
	logic [pwlcr_pkg::NIBBLE_W-1:0]     node_addr = pwlcr_pkg::ADDRESS_RESET;
	logic [pwlcr_pkg::MODE_W-1:0]       led_mode  = '0;
	logic [pwlcr_pkg::SETUP_W-1:0]      ch_setup [pwlcr_pkg::MAX_CHANNELS] = '{default: '0};
	logic [pwlcr_pkg::DUTY_W-1:0]       ch_duty [pwlcr_pkg::MAX_CHANNELS]  = '{default: '0};
	logic [pwlcr_pkg::MAX_CHANNELS-1:0] ch_enable = '0;

	pwlcr_pkg::result_t awaited_results [$];
	pwlcr_pkg::result_t seen, want;
	plan_row_t          plan [PLAN_LEN];
	int                 src_idle_pct   = 0;
	int                 sink_idle_pct  = 0;
	int                 errors         = 0;
	int                 pulses_sent    = 0;
	int                 pulses_decoded = 0;
	int                 frames_done    = 0;
	int                 results_seen   = 0;
	int                 settings_used  = 0;

	pulse_width_led_command_receiver_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Build a configuration frame with its check nibble set correctly.
	function automatic logic [pwlcr_pkg::FRAME_W-1:0] config_frame(
			logic [pwlcr_pkg::NIBBLE_W-1:0] op, logic [pwlcr_pkg::NIBBLE_W-1:0] n);
		return {~(op ^ n), n, op, pwlcr_pkg::CONFIG_NIBBLE};
	endfunction

	// Carry out a completed frame on the expected state and return its status.
	function automatic pwlcr_pkg::status_t execute_frame(logic [pwlcr_pkg::FRAME_W-1:0] f);
		logic [pwlcr_pkg::NIBBLE_W-1:0] op, n, v;
		logic [pwlcr_pkg::DUTY_W-1:0]   product;
		int                             ch;
		int                             i;
		op = f[7:4];
		n  = f[11:8];
		if (f[3:0] != pwlcr_pkg::CONFIG_NIBBLE) begin
			if (f[3:0] != node_addr)
				return pwlcr_pkg::STATUS_UNADDRESSED;
			// Drive command: each channel with a nibble selected is driven from it, or disabled if zero.
			for (i = 0; i < LED_CHANNELS; i++) begin
				if (ch_setup[i][3:2] != '0) begin
					v = f[{ch_setup[i][3:2], 2'b00} +: pwlcr_pkg::NIBBLE_W];
					if (v == '0) begin
						ch_enable[i] = 1'b0;
					end else begin
						product    = pwlcr_pkg::DUTY_W'(v) *
							(pwlcr_pkg::DUTY_W'(ch_setup[i][7:4]) + 8'd1);
						ch_duty[i] = product >> ch_setup[i][1:0];
						ch_enable[i] = 1'b1;
					end
				end
			end
			return pwlcr_pkg::STATUS_DRIVE;
		end
		// Configuration command, guarded by its check nibble.
		if (f[15:12] != ~(op ^ n))
			return pwlcr_pkg::STATUS_REJECTED;
		if (op == pwlcr_pkg::OP_ADDRESS) begin
			if (n == pwlcr_pkg::CONFIG_NIBBLE)
				return pwlcr_pkg::STATUS_REJECTED;
			node_addr = n;
		end else if (op == pwlcr_pkg::OP_MODE) begin
			if (n >= pwlcr_pkg::MODE_LIMIT)
				return pwlcr_pkg::STATUS_REJECTED;
			led_mode  = n[pwlcr_pkg::MODE_W-1:0];
			ch_enable = '0;
		end else if (op >= pwlcr_pkg::OP_LOW_FIRST && op <= pwlcr_pkg::OP_LOW_LAST) begin
			ch = int'(op - pwlcr_pkg::OP_LOW_FIRST);
			if (ch >= LED_CHANNELS)
				return pwlcr_pkg::STATUS_REJECTED;
			ch_setup[ch][3:0] = n;
			ch_enable = '0;
		end else if (op >= pwlcr_pkg::OP_GAIN_FIRST && op <= pwlcr_pkg::OP_GAIN_LAST) begin
			ch = int'(op - pwlcr_pkg::OP_GAIN_FIRST);
			if (ch >= LED_CHANNELS)
				return pwlcr_pkg::STATUS_REJECTED;
			ch_setup[ch][7:4] = n;
			ch_enable = '0;
		end else begin
			return pwlcr_pkg::STATUS_REJECTED;
		end
		return pwlcr_pkg::STATUS_APPLIED;
	endfunction

	// Classify one accepted pulse and queue the result of a frame it completes.
	function automatic void decode_pulse(logic [pwlcr_pkg::PULSE_W-1:0] p);
		pwlcr_pkg::result_t r;
		int                 i;
		if (p >= thr_break) begin
			rx_pos  = '0;
			rx_bits = '0;
			pulses_decoded++;
		end else if (rx_pos < pwlcr_pkg::POS_FULL) begin
			pulses_decoded++;
			if (p >= thr_one)
				rx_bits[rx_pos[3:0]] = 1'b1;
			rx_pos++;
			if (rx_pos == pwlcr_pkg::POS_FULL) begin
				r.status = execute_frame(rx_bits);
				for (i = 0; i < pwlcr_pkg::MAX_CHANNELS; i++)
					r.duty[i] = (i < LED_CHANNELS) ? ch_duty[i] : '0;
				r.output_enables = ch_enable;
				r.common_mode    = led_mode;
				r.node_address   = node_addr;
				awaited_results.push_back(r);
				frames_done++;
			end
		end
	endfunction

	function automatic logic [pwlcr_pkg::PULSE_W-1:0] break_pulse(bit tight);
		return tight ? thr_break : pwlcr_pkg::PULSE_W'($urandom_range(PULSE_MAX, thr_break));
	endfunction

	// A data pulse for the given bit; where the thresholds make a bit value
	// impossible the nearest pulse is sent and the prediction decides.
	function automatic logic [pwlcr_pkg::PULSE_W-1:0] bit_pulse(logic b, bit tight);
		logic [pwlcr_pkg::PULSE_W-1:0] zero_lim;
		zero_lim = (thr_one < thr_break) ? thr_one : thr_break;
		if (b && thr_one < thr_break)
			return tight ? thr_one :
				pwlcr_pkg::PULSE_W'($urandom_range(thr_break - 1, thr_one));
		if (!b && zero_lim != '0)
			return tight ? zero_lim - 1'b1 :
				pwlcr_pkg::PULSE_W'($urandom_range(zero_lim - 1, 0));
		return b ? thr_one : '0;
	endfunction

	// Pick a frame: mostly well-formed commands, some broken ones and raw noise.
	function automatic logic [pwlcr_pkg::FRAME_W-1:0] random_frame();
		logic [pwlcr_pkg::NIBBLE_W-1:0] op, n;
		int                             pick;
		pick = $urandom_range(99, 0);
		op   = pwlcr_pkg::NIBBLE_W'($urandom_range(pwlcr_pkg::OP_GAIN_LAST,
			pwlcr_pkg::OP_ADDRESS));
		n    = pwlcr_pkg::NIBBLE_W'($urandom);
		if (pick < 35)
			return {(pwlcr_pkg::FRAME_W-pwlcr_pkg::NIBBLE_W)'($urandom), node_addr};
		if (pick < 70)
			return config_frame(op, n);
		if (pick < 78)
			return config_frame(op, n) ^
				{pwlcr_pkg::NIBBLE_W'($urandom_range(15, 1)),
				(pwlcr_pkg::FRAME_W-pwlcr_pkg::NIBBLE_W)'(0)};
		if (pick < 86)
			return config_frame(pwlcr_pkg::NIBBLE_W'($urandom_range(15,
				pwlcr_pkg::OP_GAIN_LAST + 1)), n);
		return pwlcr_pkg::FRAME_W'($urandom);
	endfunction

	// Offer one pulse, with random idle cycles ahead of it, and wait for the transaction.
	task automatic send_pulse(logic [pwlcr_pkg::PULSE_W-1:0] p);
		while ($urandom_range(99, 0) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= p;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		decode_pulse(p);
		pulses_sent++;
	endtask

	task automatic send_frame(logic [pwlcr_pkg::FRAME_W-1:0] bits, bit tight);
		int i;
		send_pulse(break_pulse(tight));
		for (i = 0; i < pwlcr_pkg::FRAME_W; i++)
			send_pulse(bit_pulse(bits[i], tight));
	endtask

	// Stop sending, wait for every expected result, then let the pipeline empty.
	task automatic settle();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (awaited_results.size() != 0) begin
			$display("%0t: %0d expected result transactions never arrived", $time,
				awaited_results.size());
			errors += awaited_results.size();
			awaited_results.delete();
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_thresholds(logic [pwlcr_pkg::THRESH_W-1:0] brk,
			logic [pwlcr_pkg::THRESH_W-1:0] one);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= pwlcr_pkg::REG_BREAK_THRESHOLD;
		cfg_wdata <= brk;
		@(posedge clk);
		cfg_index <= pwlcr_pkg::REG_ONE_THRESHOLD;
		cfg_wdata <= one;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		thr_break = brk;
		thr_one   = one;
		settings_used++;
	endtask

	function automatic void compare_field(string name, int expected, int actual);
		if (expected != actual) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected,
				actual);
			errors++;
		end
	endfunction

	// The result side stalls at random, at the rate of the current phase.
	always @(posedge clk) begin
		m_tready <= $urandom_range(99, 0) >= sink_idle_pct;
	end

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen = pwlcr_pkg::result_t'(m_tdata[RESULT_W-1:0]);
			results_seen++;
			if (awaited_results.size() == 0) begin
				$display("%0t: result transaction with nothing expected, actual %h", $time,
					m_tdata);
				errors++;
			end else begin
				want = awaited_results.pop_front();
				compare_field("status", want.status, seen.status);
				compare_field("duty_first", want.duty[0], seen.duty[0]);
				compare_field("duty_second", want.duty[1], seen.duty[1]);
				compare_field("duty_third", want.duty[2], seen.duty[2]);
				compare_field("output_enables", want.output_enables, seen.output_enables);
				compare_field("common_mode", want.common_mode, seen.common_mode);
				compare_field("node_address", want.node_address, seen.node_address);
				compare_field("padding", 0, int'(m_tdata >> RESULT_W));
			end
		end
	end

	initial begin : stimulus
		plan_row_t row;
		int        r, k, seg, brk, one, pick, decoded_before, done_before;

		// Directed plan: address set-up, channel set-up, drive commands and every rejection.
		plan[0]  = '{pwlcr_pkg::BREAK_THRESHOLD_RESET, pwlcr_pkg::ONE_THRESHOLD_RESET, 3, 0,
			config_frame(pwlcr_pkg::OP_ADDRESS, 4'd3), 1'b1, 1'b1, pwlcr_pkg::STATUS_APPLIED};
		plan[1]  = '{pwlcr_pkg::BREAK_THRESHOLD_RESET, pwlcr_pkg::ONE_THRESHOLD_RESET, 0, 0,
			16'h0003, 1'b0, 1'b1, pwlcr_pkg::STATUS_DRIVE};
		plan[2]  = '{pwlcr_pkg::BREAK_THRESHOLD_RESET, pwlcr_pkg::ONE_THRESHOLD_RESET, 0, 5,
			16'h1235, 1'b1, 1'b1, pwlcr_pkg::STATUS_UNADDRESSED};
		plan[3]  = '{pwlcr_pkg::BREAK_THRESHOLD_RESET, pwlcr_pkg::ONE_THRESHOLD_RESET, 0, 0,
			config_frame(pwlcr_pkg::OP_LOW_FIRST, 4'b0100), 1'b0, 1'b0,
			pwlcr_pkg::STATUS_UNADDRESSED};
		plan[4]  = '{pwlcr_pkg::BREAK_THRESHOLD_RESET, pwlcr_pkg::ONE_THRESHOLD_RESET, 0, 0,
			config_frame(pwlcr_pkg::OP_GAIN_FIRST, 4'hf), 1'b1, 1'b0,
			pwlcr_pkg::STATUS_UNADDRESSED};
		plan[5]  = '{pwlcr_pkg::BREAK_THRESHOLD_RESET, pwlcr_pkg::ONE_THRESHOLD_RESET, 0, 0,
			16'h00f3, 1'b0, 1'b0, pwlcr_pkg::STATUS_UNADDRESSED};
		plan[6]  = '{pwlcr_pkg::BREAK_THRESHOLD_RESET, pwlcr_pkg::ONE_THRESHOLD_RESET, 0, 0,
			config_frame(pwlcr_pkg::OP_LOW_FIRST + 4'd1, 4'b1011), 1'b0, 1'b0,
			pwlcr_pkg::STATUS_UNADDRESSED};
		plan[7]  = '{pwlcr_pkg::BREAK_THRESHOLD_RESET, pwlcr_pkg::ONE_THRESHOLD_RESET, 0, 0,
			config_frame(pwlcr_pkg::OP_GAIN_LAST, 4'h7), 1'b0, 1'b0,
			pwlcr_pkg::STATUS_UNADDRESSED};
		plan[8]  = '{pwlcr_pkg::BREAK_THRESHOLD_RESET, pwlcr_pkg::ONE_THRESHOLD_RESET, 0, 0,
			config_frame(pwlcr_pkg::OP_LOW_LAST, 4'b1110), 1'b0, 1'b0,
			pwlcr_pkg::STATUS_UNADDRESSED};
		plan[9]  = '{pwlcr_pkg::BREAK_THRESHOLD_RESET, pwlcr_pkg::ONE_THRESHOLD_RESET, 0, 0,
			16'hf5a3, 1'b1, 1'b0, pwlcr_pkg::STATUS_UNADDRESSED};
		plan[10] = '{pwlcr_pkg::BREAK_THRESHOLD_RESET, pwlcr_pkg::ONE_THRESHOLD_RESET, 4, 0,
			16'h0003, 1'b0, 1'b0, pwlcr_pkg::STATUS_UNADDRESSED};
		plan[11] = '{pwlcr_pkg::BREAK_THRESHOLD_RESET, pwlcr_pkg::ONE_THRESHOLD_RESET, 0, 0,
			config_frame(pwlcr_pkg::OP_MODE, 4'd2), 1'b0, 1'b1, pwlcr_pkg::STATUS_APPLIED};
		plan[12] = '{pwlcr_pkg::BREAK_THRESHOLD_RESET, pwlcr_pkg::ONE_THRESHOLD_RESET, 0, 0,
			config_frame(pwlcr_pkg::OP_MODE, pwlcr_pkg::MODE_LIMIT), 1'b0, 1'b1,
			pwlcr_pkg::STATUS_REJECTED};
		plan[13] = '{pwlcr_pkg::BREAK_THRESHOLD_RESET, pwlcr_pkg::ONE_THRESHOLD_RESET, 0, 0,
			config_frame(pwlcr_pkg::OP_ADDRESS, pwlcr_pkg::CONFIG_NIBBLE), 1'b0, 1'b1,
			pwlcr_pkg::STATUS_REJECTED};
		plan[14] = '{pwlcr_pkg::BREAK_THRESHOLD_RESET, pwlcr_pkg::ONE_THRESHOLD_RESET, 0, 0,
			config_frame(pwlcr_pkg::OP_ADDRESS, 4'd1) ^ 16'h1000, 1'b0, 1'b1,
			pwlcr_pkg::STATUS_REJECTED};
		plan[15] = '{pwlcr_pkg::BREAK_THRESHOLD_RESET, pwlcr_pkg::ONE_THRESHOLD_RESET, 0, 0,
			config_frame(pwlcr_pkg::OP_GAIN_LAST + 4'd1, 4'd0), 1'b0, 1'b1,
			pwlcr_pkg::STATUS_REJECTED};
		plan[16] = '{pwlcr_pkg::BREAK_THRESHOLD_RESET, pwlcr_pkg::ONE_THRESHOLD_RESET, 0, 0,
			config_frame(pwlcr_pkg::OP_GAIN_LAST + 4'd8, 4'd5), 1'b0, 1'b1,
			pwlcr_pkg::STATUS_REJECTED};
		plan[17] = '{pwlcr_pkg::BREAK_THRESHOLD_RESET, pwlcr_pkg::ONE_THRESHOLD_RESET, 0, 0,
			config_frame(pwlcr_pkg::OP_GAIN_FIRST + 4'd1, 4'd0), 1'b0, 1'b0,
			pwlcr_pkg::STATUS_UNADDRESSED};
		// Threshold corners: every pulse a break, every data bit a one, every data bit a zero, then the widest spans.
		plan[18] = '{8'd0, pwlcr_pkg::ONE_THRESHOLD_RESET, 0, 0, 16'hffff, 1'b0, 1'b0,
			pwlcr_pkg::STATUS_UNADDRESSED};
		plan[19] = '{8'hff, 8'd0, 0, 0, 16'h0000, 1'b0, 1'b1, pwlcr_pkg::STATUS_REJECTED};
		plan[20] = '{8'd1, 8'hff, 2, 0, 16'h0000, 1'b1, 1'b1, pwlcr_pkg::STATUS_UNADDRESSED};
		plan[21] = '{8'hff, 8'd1, 2, 3, 16'h9c63, 1'b0, 1'b0, pwlcr_pkg::STATUS_UNADDRESSED};
		plan[22] = '{8'hff, 8'd1, 0, 0, 16'hf0f3, 1'b1, 1'b0, pwlcr_pkg::STATUS_UNADDRESSED};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: the typed status stands in for the prediction where it is given.
		for (r = 0; r < PLAN_LEN; r++) begin
			row = plan[r];
			if (row.brk != thr_break || row.one != thr_one)
				set_thresholds(row.brk, row.one);
			for (k = 0; k < row.strays; k++)
				send_pulse(pwlcr_pkg::PULSE_W'($urandom_range(row.brk - 1, 0)));
			if (row.partial > 0) begin
				send_pulse(break_pulse(1'b0));
				for (k = 0; k < row.partial; k++)
					send_pulse(bit_pulse(1'($urandom_range(1, 0)), 1'b0));
			end
			done_before = frames_done;
			send_frame(row.bits, row.tight);
			if (row.known) begin
				if (frames_done == done_before) begin
					$display("%0t: directed frame %0d completed no frame in the prediction",
						$time, r);
					errors++;
				end else begin
					awaited_results[$].status = row.status;
				end
			end
		end

		// Random part: six threshold settings over three pacing regimes.
		for (seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: begin
					brk = pwlcr_pkg::BREAK_THRESHOLD_RESET;
					one = pwlcr_pkg::ONE_THRESHOLD_RESET;
				end
				1: begin
					brk = 255;
					one = 1;
				end
				3: begin
					brk = 2;
					one = 1;
				end
				4: begin
					brk = 255;
					one = 254;
				end
				default: begin
					brk = $urandom_range(255, 3);
					one = $urandom_range(brk - 1, 1);
				end
			endcase
			set_thresholds(pwlcr_pkg::THRESH_W'(brk), pwlcr_pkg::THRESH_W'(one));
			src_idle_pct  = (seg < 2) ? 9 : (seg < 4) ? 81 : 0;
			sink_idle_pct = (seg < 2) ? 81 : (seg < 4) ? 9 : 0;
			decoded_before = pulses_decoded;
			while (pulses_decoded - decoded_before < ITEMS_PER_SEGMENT) begin
				pick = $urandom_range(99, 0);
				if (pick < 6) begin
					// A loose pulse of any length.
					send_pulse(pwlcr_pkg::PULSE_W'($urandom));
				end else if (pick < 12) begin
					// A frame cut short; the next break drops it.
					send_pulse(break_pulse(1'b0));
					repeat ($urandom_range(15, 1))
						send_pulse(bit_pulse(1'($urandom_range(1, 0)), 1'b0));
				end else if (pick < 16) begin
					// Data pulses trailing a finished frame.
					send_pulse(bit_pulse(1'($urandom_range(1, 0)), 1'b0));
				end else begin
					send_frame(random_frame(), $urandom_range(9, 0) == 0);
				end
			end
		end

		settle();
		$display("Run covered %0d pulse transactions, %0d of them decoded, and %0d results,",
			pulses_sent, pulses_decoded, results_seen);
		$display("across %0d threshold settings and three stall patterns.", settings_used);
		if (errors == 0)
			$display("tb_pulse_width_led_command_receiver_unit: PASS");
		else
			$display("tb_pulse_width_led_command_receiver_unit: FAIL");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin : watchdog
		#3_000_000;
		$display("tb_pulse_width_led_command_receiver_unit: FAIL");
		$finish;
	end

endmodule
